[hdl/casg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// casg_pkg: shared types and constants of the arc step generator
// Datapath operation codes and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package casg_pkg;

   localparam int COORD_BITS_DEF = 16;   // offset width after wrap
   localparam int PART_COUNT     = 5;    // quadrant parts of a full loop
   localparam int PART_IDX_BITS  = 3;
   localparam int IN_BITS        = 15;   // width of the point fields

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,    // latch offsets and direction
      OP_PROD1,   // start x * end y
      OP_PROD2,   // compare against start y * end x, build the part plan
      OP_SQX,     // walk x squared
      OP_SQY,     // plus walk y squared, arm the root unit
      OP_C1,      // target x * walk y
      OP_C2,      // minus target y * walk x
      OP_SQRT,    // one root iteration
      OP_ROUND,   // round the root, seed the decision
      OP_SWAP,    // next part, swap the walk point
      OP_STEP,    // one move, result beat
      OP_FIN      // finished result beat
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic step_ok;    // cross product still on the start side
      logic at_last;    // current part is the last one
      logic root_done;  // root unit on its final iteration
   } status_type;

endpackage : casg_pkg
`default_nettype wire

[hdl/circular_arc_step_generator.sv]
`default_nettype none
// Start beat: setup of two products, the part setup and COORD_BITS+1 root
//   iterations; busy is high throughout.
// Step beat: decided in ST_CHECK, move registered into the result beat; busy
//   holds off the next beat until idle. A part change reruns the part setup
//   and the one-bit-a-cycle root unit. A step while idle answers finished in
//   the cycle after accept. Single-cycle rsp_strobe beats; no receiver stall.
// Synchronous reset: idle, step beats answer finished until a start beat.
// ----------------------------------------------------------------------------
// circular_arc_step_generator: arc interpolator for a stepper plotter
// A start beat plans up to five quadrant parts; each step beat returns one
// unit move from an Andres circle decision, or finished.
// ----------------------------------------------------------------------------
module circular_arc_step_generator #(
   parameter int COORD_BITS = casg_pkg::COORD_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_type,
   input  wire logic signed [casg_pkg::IN_BITS-1:0] req_start_x,
   input  wire logic signed [casg_pkg::IN_BITS-1:0] req_start_y,
   input  wire logic signed [casg_pkg::IN_BITS-1:0] req_end_x,
   input  wire logic signed [casg_pkg::IN_BITS-1:0] req_end_y,
   input  wire logic signed [casg_pkg::IN_BITS-1:0] req_center_x,
   input  wire logic signed [casg_pkg::IN_BITS-1:0] req_center_y,
   input  wire logic                                req_clockwise,
   output logic                                     rsp_strobe,
   output logic signed [1:0]                        rsp_step_x,
   output logic signed [1:0]                        rsp_step_y,
   output logic                                     rsp_finished
);
   import casg_pkg::*;

   cmd_type    cmd;     // one datapath operation per cycle
   status_type status;  // decision inputs back to the sequencer

   // sequencer: setup order, root loop, move / part change / finish choice
   casg_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // datapath: offsets, part plan, multiplier, root, walk, result register
   casg_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_clockwise (req_clockwise),
      .status        (status),
      .rsp_strobe    (rsp_strobe),
      .rsp_step_x    (rsp_step_x),
      .rsp_step_y    (rsp_step_y),
      .rsp_finished  (rsp_finished)
   );

endmodule : circular_arc_step_generator
`default_nettype wire

[hdl/casg_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// casg_ctrl: sequencer of the arc step generator
// Walks the start setup, the part setup and the root iterations, and
// decides per step request between move, part change and finish.
// ----------------------------------------------------------------------------
module casg_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                req_type,
   input  wire casg_pkg::status_type status,
   output casg_pkg::cmd_type        cmd,
   output logic                     busy
);
   import casg_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PROD1 = 4'd1;
   localparam logic [3:0] ST_PROD2 = 4'd2;
   localparam logic [3:0] ST_SQX   = 4'd3;
   localparam logic [3:0] ST_SQY   = 4'd4;
   localparam logic [3:0] ST_C1    = 4'd5;
   localparam logic [3:0] ST_C2    = 4'd6;
   localparam logic [3:0] ST_SQRT  = 4'd7;
   localparam logic [3:0] ST_ROUND = 4'd8;
   localparam logic [3:0] ST_CHECK = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       run_ff, run_in;
   logic       in_step_ff, in_step_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      run_in     = run_ff;
      in_step_in = in_step_ff;
      cmd.op     = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_type == 1'b0) begin
                  cmd.op   = OP_LOAD;
                  state_in = ST_PROD1;
               end else if (run_ff) begin
                  in_step_in = 1'b1;
                  state_in   = ST_CHECK;
               end else begin
                  cmd.op = OP_FIN;
               end
            end
         end
         ST_PROD1: begin
            cmd.op   = OP_PROD1;
            state_in = ST_PROD2;
         end
         ST_PROD2: begin
            cmd.op     = OP_PROD2;
            run_in     = 1'b1;
            in_step_in = 1'b0;
            state_in   = ST_SQX;
         end
         ST_SQX: begin
            cmd.op   = OP_SQX;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.op   = OP_SQY;
            state_in = ST_C1;
         end
         ST_C1: begin
            cmd.op   = OP_C1;
            state_in = ST_C2;
         end
         ST_C2: begin
            cmd.op   = OP_C2;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op = OP_SQRT;
            if (status.root_done) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.op   = OP_ROUND;
            state_in = in_step_ff ? ST_CHECK : ST_IDLE;
         end
         ST_CHECK: begin
            priority if (status.step_ok) begin
               cmd.op   = OP_STEP;
               state_in = ST_IDLE;
            end else if (status.at_last) begin
               cmd.op   = OP_FIN;
               run_in   = 1'b0;
               state_in = ST_IDLE;
            end else begin
               cmd.op   = OP_SWAP;
               state_in = ST_SQX;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         run_ff     <= 1'b0;
         in_step_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         run_ff     <= run_in;
         in_step_ff <= in_step_in;
      end
   end

endmodule : casg_ctrl
`default_nettype wire

[hdl/casg_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// casg_dp: datapath of the arc step generator
// Offsets, part plan, shared multiplier, bit-serial root, decision walk
// and the registered result beat.
// ----------------------------------------------------------------------------
module casg_dp #(
   parameter int COORD_BITS = casg_pkg::COORD_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire casg_pkg::cmd_type                   cmd,
   input  wire logic signed [casg_pkg::IN_BITS-1:0] req_start_x,
   input  wire logic signed [casg_pkg::IN_BITS-1:0] req_start_y,
   input  wire logic signed [casg_pkg::IN_BITS-1:0] req_end_x,
   input  wire logic signed [casg_pkg::IN_BITS-1:0] req_end_y,
   input  wire logic signed [casg_pkg::IN_BITS-1:0] req_center_x,
   input  wire logic signed [casg_pkg::IN_BITS-1:0] req_center_y,
   input  wire logic                                req_clockwise,
   output casg_pkg::status_type                     status,
   output logic                                     rsp_strobe,
   output logic signed [1:0]                        rsp_step_x,
   output logic signed [1:0]                        rsp_step_y,
   output logic                                     rsp_finished
);
   import casg_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int N  = CB + 1;       // normalized coordinate
   localparam int W  = CB + 2;       // walk coordinate, multiplier operand
   localparam int R  = CB + 1;       // radius
   localparam int D  = CB + 6;       // decision
   localparam int P  = 2 * W;        // product, cross value
   localparam int Q  = 2 * CB + 2;   // sum of squares
   localparam int KB = $clog2(CB + 1);

   function automatic logic signed [CB-1:0] wrap_off(input logic signed [IN_BITS-1:0] a,
                                                     input logic signed [IN_BITS-1:0] b);
      logic signed [IN_BITS:0]         d;
      logic signed [CB+IN_BITS:0]      e;
      d = {a[IN_BITS-1], a} - {b[IN_BITS-1], b};
      e = {{CB{d[IN_BITS]}}, d};
      return e[CB-1:0];
   endfunction

   function automatic logic [1:0] part_quad(input logic [1:0] qi, input logic cw,
                                            input logic [PART_IDX_BITS-1:0] idx);
      return cw ? (qi + idx[1:0]) : (qi - idx[1:0]);
   endfunction

   // normalized pair packed as {nx, ny}
   function automatic logic [2*N-1:0] to_norm(input logic [1:0] q, input logic sw,
                                              input logic signed [CB-1:0] x,
                                              input logic signed [CB-1:0] y);
      logic signed [N-1:0] xe, ye, xs, ys;
      xe = {x[CB-1], x};
      ye = {y[CB-1], y};
      xs = (q[1] == 1'b0) ? xe : -xe;
      ys = (q == 2'd0 || q == 2'd3) ? ye : -ye;
      return sw ? {ys, xs} : {xs, ys};
   endfunction

   logic signed [CB-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic                 cw_ff;
   logic [1:0]           qi_ff;
   logic [PART_IDX_BITS-1:0] last_ff, cur_ff;
   logic signed [N-1:0]  lex_ff, ley_ff;
   logic signed [W-1:0]  wx_ff, wy_ff;
   logic [R-1:0]         radius_ff;
   logic signed [D-1:0]  dec_ff;
   logic signed [P-1:0]  cross_ff, acc_ff;
   logic                 isign_ff;
   logic [Q-1:0]         rem_ff, res_ff;
   logic [KB-1:0]        k_ff;
   logic                 strobe_ff;
   logic signed [1:0]    ox_ff, oy_ff;
   logic                 fin_ff;

   // quadrants of the offsets
   logic [1:0] qs, qe;
   logic signed [CB-1:0] osx, osy, oex, oey;
   assign osx = wrap_off(req_start_x, req_center_x);
   assign osy = wrap_off(req_start_y, req_center_y);
   assign oex = wrap_off(req_end_x, req_center_x);
   assign oey = wrap_off(req_end_y, req_center_y);

   always_comb begin
      qs = sx_ff[CB-1] ? (sy_ff[CB-1] ? 2'd2 : 2'd3) : (sy_ff[CB-1] ? 2'd1 : 2'd0);
      qe = ex_ff[CB-1] ? (ey_ff[CB-1] ? 2'd2 : 2'd3) : (ey_ff[CB-1] ? 2'd1 : 2'd0);
   end

   // target ray of the current part
   logic signed [N-1:0] tx, ty;
   always_comb begin
      if (cur_ff == last_ff) begin
         tx = lex_ff;
         ty = ley_ff;
      end else begin
         tx = N'(1);
         ty = '0;
      end
   end

   // shared multiplier
   logic signed [W-1:0] ma, mb;
   logic signed [P-1:0] prod;
   always_comb begin
      ma = '0;
      mb = '0;
      unique case (cmd.op)
         OP_PROD1: begin
            ma = {{2{sx_ff[CB-1]}}, sx_ff};
            mb = {{2{ey_ff[CB-1]}}, ey_ff};
         end
         OP_PROD2: begin
            ma = {{2{sy_ff[CB-1]}}, sy_ff};
            mb = {{2{ex_ff[CB-1]}}, ex_ff};
         end
         OP_SQX: begin
            ma = wx_ff;
            mb = wx_ff;
         end
         OP_SQY: begin
            ma = wy_ff;
            mb = wy_ff;
         end
         OP_C1: begin
            ma = {tx[N-1], tx};
            mb = wy_ff;
         end
         OP_C2: begin
            ma = {ty[N-1], ty};
            mb = wx_ff;
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end
   assign prod = ma * mb;

   // part plan
   logic                     fwd;
   logic [PART_IDX_BITS-1:0] last_new;
   logic [1:0]               q_last, q_cur;
   logic [2*N-1:0]           n_first, n_last;
   always_comb begin
      fwd = (acc_ff > prod);
      if (qs == qe) begin
         last_new = (fwd == cw_ff) ? PART_IDX_BITS'(PART_COUNT - 1) : '0;
      end else begin
         last_new = {1'b0, (cw_ff ? (qe - qs) : (qs - qe))};
      end
      q_last  = part_quad(qs, cw_ff, last_new);
      n_first = to_norm(qs, qs[0] ^ ~cw_ff, sx_ff, sy_ff);
      n_last  = to_norm(q_last, q_last[0] ^ ~cw_ff, ex_ff, ey_ff);
      q_cur   = part_quad(qi_ff, cw_ff, cur_ff);
   end

   // root iteration
   logic [Q-1:0] bitv, trial, rnd;
   always_comb begin
      bitv  = Q'(1) << {k_ff, 1'b0};
      trial = res_ff + bitv;
      rnd   = (rem_ff > res_ff) ? (res_ff + Q'(1)) : res_ff;
   end

   // decision walk
   logic signed [D-1:0] wxd, wyd, two_wx, two_ry, dec_in;
   logic signed [P-1:0] txp, typ, cross_in;
   logic                mvx, mvy;
   logic signed [W-1:0] wx_in, wy_in;
   logic signed [1:0]   sdx, sdy, ox, oy;
   always_comb begin
      wxd    = {{(D-W){wx_ff[W-1]}}, wx_ff};
      wyd    = {{(D-W){wy_ff[W-1]}}, wy_ff};
      txp    = {{(P-N){tx[N-1]}}, tx};
      typ    = {{(P-N){ty[N-1]}}, ty};
      two_wx = wxd <<< 1;
      two_ry = ({{(D-R){1'b0}}, radius_ff} - wyd) <<< 1;
      priority if (dec_ff >= two_wx) begin
         dec_in   = dec_ff - two_wx - D'(1);
         wx_in    = wx_ff + W'(1);
         wy_in    = wy_ff;
         cross_in = cross_ff - typ;
         mvx      = 1'b1;
         mvy      = 1'b0;
      end else if (dec_ff < two_ry) begin
         dec_in   = dec_ff + (wyd <<< 1) - D'(1);
         wx_in    = wx_ff;
         wy_in    = wy_ff - W'(1);
         cross_in = cross_ff - txp;
         mvx      = 1'b0;
         mvy      = 1'b1;
      end else begin
         dec_in   = dec_ff + ((wyd - wxd - D'(1)) <<< 1);
         wx_in    = wx_ff + W'(1);
         wy_in    = wy_ff - W'(1);
         cross_in = cross_ff - txp - typ;
         mvx      = 1'b1;
         mvy      = 1'b1;
      end
      sdx = (q_cur[1] == 1'b0) ? 2'sd1 : -2'sd1;
      sdy = (q_cur == 2'd0 || q_cur == 2'd3) ? 2'sd1 : -2'sd1;
      if (q_cur[0] ^ ~cw_ff) begin
         ox = mvy ? -sdx : 2'sd0;
         oy = mvx ? sdy : 2'sd0;
      end else begin
         ox = mvx ? sdx : 2'sd0;
         oy = mvy ? -sdy : 2'sd0;
      end
   end

   always_comb begin
      status.step_ok   = (cross_ff != '0) && (isign_ff == (cross_ff > 0));
      status.at_last   = (cur_ff >= last_ff);
      status.root_done = (k_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (cmd.op == OP_STEP) || (cmd.op == OP_FIN);
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            sx_ff <= osx;
            sy_ff <= osy;
            ex_ff <= oex;
            ey_ff <= oey;
            cw_ff <= req_clockwise;
         end
         OP_PROD1: begin
            acc_ff <= prod;
         end
         OP_PROD2: begin
            qi_ff   <= qs;
            last_ff <= last_new;
            cur_ff  <= '0;
            wx_ff   <= {n_first[2*N-1], n_first[2*N-1:N]};
            wy_ff   <= {n_first[N-1], n_first[N-1:0]};
            lex_ff  <= n_last[2*N-1:N];
            ley_ff  <= n_last[N-1:0];
         end
         OP_SQX: begin
            acc_ff <= prod;
         end
         OP_SQY: begin
            rem_ff <= acc_ff[Q-1:0] + prod[Q-1:0];
            res_ff <= '0;
            k_ff   <= KB'(CB);
         end
         OP_C1: begin
            acc_ff <= prod;
         end
         OP_C2: begin
            cross_ff <= acc_ff - prod;
            isign_ff <= (acc_ff - prod) > 0;
         end
         OP_SQRT: begin
            if (rem_ff >= trial) begin
               rem_ff <= rem_ff - trial;
               res_ff <= (res_ff >> 1) + bitv;
            end else begin
               res_ff <= res_ff >> 1;
            end
            k_ff <= k_ff - KB'(1);
         end
         OP_ROUND: begin
            radius_ff <= rnd[R-1:0];
            dec_ff    <= {{(D-R){1'b0}}, rnd[R-1:0]} - D'(1);
         end
         OP_SWAP: begin
            cur_ff <= cur_ff + PART_IDX_BITS'(1);
            wx_ff  <= wy_ff;
            wy_ff  <= wx_ff;
         end
         OP_STEP: begin
            dec_ff   <= dec_in;
            wx_ff    <= wx_in;
            wy_ff    <= wy_in;
            cross_ff <= cross_in;
            ox_ff    <= ox;
            oy_ff    <= oy;
            fin_ff   <= 1'b0;
         end
         OP_FIN: begin
            ox_ff  <= 2'sd0;
            oy_ff  <= 2'sd0;
            fin_ff <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_step_x   = ox_ff;
   assign rsp_step_y   = oy_ff;
   assign rsp_finished = fin_ff;

endmodule : casg_dp
`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for circular_arc_step_generator
// Drives start and step beats, predicts each move with an in-bench copy of
// the arc walk, and checks every rsp_strobe beat against the oldest
// predicted move.
// ----------------------------------------------------------------------------
module testbench;

   localparam int W = casg_pkg::IN_BITS;

   typedef logic signed [W-1:0] coord_type;

   typedef struct {
      logic signed [1:0] dx;
      logic signed [1:0] dy;
      logic              done;
   } move_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic req_type;
   coord_type req_start_x, req_start_y, req_end_x, req_end_y;
   coord_type req_center_x, req_center_y;
   logic req_clockwise;
   logic rsp_strobe;
   logic signed [1:0] rsp_step_x, rsp_step_y;
   logic rsp_finished;

   circular_arc_step_generator u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_clockwise(req_clockwise),
      .rsp_strobe(rsp_strobe), .rsp_step_x(rsp_step_x),
      .rsp_step_y(rsp_step_y), .rsp_finished(rsp_finished)
   );

   // predicted moves, oldest first
   move_type pending_moves[$];
   int    mismatch_count = 0;
   int    beats_sent = 0;
   int    gap_pct = 0;

   // arc walk state of the predictor
   logic [2:0] plan[5];        // bits 1..0 quadrant, bit 2 swap
   longint     first_nx, first_ny, end_nx, end_ny;
   int         last_part, cur_part;
   longint     walk_x, walk_y, radius, decision, cross_val;
   bit         side0;
   bit         walking;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint wrap16(longint v);
      logic signed [15:0] t;
      t = v[15:0];
      return longint'(t);
   endfunction

   function automatic int quad_of(longint x, longint y);
      if (x >= 0) return (y >= 0) ? 0 : 1;
      return (y < 0) ? 2 : 3;
   endfunction

   function automatic longint sgn_x(int q);
      return (q == 0 || q == 1) ? 1 : -1;
   endfunction

   function automatic longint sgn_y(int q);
      return (q == 0 || q == 3) ? 1 : -1;
   endfunction

   function automatic logic [2:0] part_of(int q, bit cw);
      logic sw;
      sw = q[0] ^ ~cw;
      return {sw, q[1:0]};
   endfunction

   function automatic void normalize(logic [2:0] p, longint x, longint y,
                                     output longint nx, output longint ny);
      int q;
      q = int'(p[1:0]);
      if (p[2]) begin
         nx = y * sgn_y(q);
         ny = x * sgn_x(q);
      end else begin
         nx = x * sgn_x(q);
         ny = y * sgn_y(q);
      end
   endfunction

   // nearest-integer square root, bit-serial
   function automatic longint root_nearest(longint unsigned n);
      longint unsigned res, b, rem;
      res = 0;
      b = 64'd1 << 62;
      rem = n;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (rem >= res + b) begin
            rem -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      if (n - res * res > res) res++;
      return longint'(res);
   endfunction

   function automatic void open_part(longint px, longint py);
      longint tx, ty;
      tx = 1;
      ty = 0;
      if (cur_part == last_part) begin
         tx = end_nx;
         ty = end_ny;
      end
      walk_x = px;
      walk_y = py;
      radius = root_nearest(longint'(px * px + py * py));
      cross_val = tx * py - ty * px;
      side0 = cross_val > 0;
      decision = radius - 1;
   endfunction

   function automatic void plan_arc(coord_type s_x, coord_type s_y, coord_type e_x,
                                    coord_type e_y, coord_type c_x, coord_type c_y,
                                    bit cw);
      longint sx, sy, ex, ey;
      int qi, qf, adv, q;
      sx = wrap16(longint'(s_x) - longint'(c_x));
      sy = wrap16(longint'(s_y) - longint'(c_y));
      ex = wrap16(longint'(e_x) - longint'(c_x));
      ey = wrap16(longint'(e_y) - longint'(c_y));
      qi = quad_of(sx, sy);
      qf = quad_of(ex, ey);
      adv = cw ? 1 : 3;
      plan[0] = part_of(qi, cw);
      normalize(plan[0], sx, sy, first_nx, first_ny);
      if (qi == qf) begin
         if ((sx * ey > sy * ex) == cw) begin
            for (int i = 1; i < 5; i++) plan[i] = part_of((qi + adv * i) & 3, cw);
            last_part = 4;
         end else begin
            last_part = 0;
         end
      end else begin
         q = qi;
         last_part = 0;
         do begin
            last_part++;
            q = (q + adv) & 3;
            plan[last_part] = part_of(q, cw);
         end while (q != qf && last_part < 4);
      end
      normalize(plan[last_part], ex, ey, end_nx, end_ny);
      cur_part = 0;
      open_part(first_nx, first_ny);
      walking = 1;
   endfunction

   function automatic move_type next_move();
      move_type m;
      longint mx, my, ox, oy, tx, ty;
      logic [2:0] p;
      int q;
      m.dx = 2'sd0;
      m.dy = 2'sd0;
      m.done = 1'b1;
      if (!walking) return m;
      forever begin
         if (cross_val != 0 && side0 == (cross_val > 0)) begin
            p = plan[cur_part];
            q = int'(p[1:0]);
            tx = 1;
            ty = 0;
            if (cur_part == last_part) begin
               tx = end_nx;
               ty = end_ny;
            end
            if (decision >= 2 * walk_x) begin
               decision -= 2 * walk_x + 1;
               walk_x++;
               cross_val -= ty;
               mx = 1;
               my = 0;
            end else if (decision < 2 * (radius - walk_y)) begin
               decision += 2 * walk_y - 1;
               walk_y--;
               cross_val -= tx;
               mx = 0;
               my = -1;
            end else begin
               decision += 2 * (walk_y - walk_x - 1);
               walk_y--;
               walk_x++;
               cross_val -= tx + ty;
               mx = 1;
               my = -1;
            end
            if (p[2]) begin
               ox = my * sgn_x(q);
               oy = mx * sgn_y(q);
            end else begin
               ox = mx * sgn_x(q);
               oy = my * sgn_y(q);
            end
            m.dx = ox[1:0];
            m.dy = oy[1:0];
            m.done = 1'b0;
            return m;
         end
         if (cur_part >= last_part) begin
            walking = 0;
            return m;
         end
         cur_part++;
         open_part(walk_y, walk_x);   // swap into the next quadrant's frame
      end
   endfunction

   // ---------------------------------------------------------------- driver
   // One beat; start is left high on return so back-to-back beats need no
   // second assignment in the same step.
   task automatic send_beat(bit is_step, coord_type s_x, coord_type s_y, coord_type e_x,
                            coord_type e_y, coord_type c_x, coord_type c_y, bit cw);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_type      <= is_step;
      req_start_x   <= s_x;
      req_start_y   <= s_y;
      req_end_x     <= e_x;
      req_end_y     <= e_y;
      req_center_x  <= c_x;
      req_center_y  <= c_y;
      req_clockwise <= cw;
      do @(posedge clock); while (busy);
      beats_sent++;
      if (is_step) pending_moves.push_back(next_move());
      else plan_arc(s_x, s_y, e_x, e_y, c_x, c_y, cw);
   endtask

   task automatic step_beat();
      coord_type junk;
      junk = coord_type'($urandom);
      send_beat(1'b1, junk, coord_type'($urandom), junk, coord_type'($urandom),
                coord_type'($urandom), junk, 1'($urandom));
   endtask

   // start an arc and step it until finished or the step budget runs out
   task automatic walk_arc(coord_type s_x, coord_type s_y, coord_type e_x, coord_type e_y,
                           coord_type c_x, coord_type c_y, bit cw, int budget);
      int n;
      send_beat(1'b0, s_x, s_y, e_x, e_y, c_x, c_y, cw);
      n = 0;
      while (n < budget) begin
         step_beat();
         n++;
         if (!walking) break;
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_moves.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      move_type want;
      if (!reset && rsp_strobe) begin
         if (pending_moves.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: x=%0d y=%0d fin=%0b",
                        rsp_step_x, rsp_step_y, rsp_finished);
         end else begin
            want = pending_moves.pop_front();
            if (rsp_step_x !== want.dx || rsp_step_y !== want.dy ||
                rsp_finished !== want.done) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("move mismatch: exp x=%0d y=%0d fin=%0b, got x=%0d y=%0d fin=%0b",
                           want.dx, want.dy, want.done,
                           rsp_step_x, rsp_step_y, rsp_finished);
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_idle_steps();
      step_beat();
      step_beat();
      drain();
   endtask

   task automatic test_full_loops();
      walk_arc(10, 0, 10, 1, 0, 0, 1'b1, 200);       // cw, end just behind start
      walk_arc(0, 7, 0, 3, 0, 0, 1'b0, 200);         // ccw, end on start ray
      walk_arc(-6, -2, -6, -2, 0, 0, 1'b1, 10);      // cw, end on start ray: finishes at once
      step_beat();                                   // stays finished
      drain();
   endtask

   task automatic test_crossings();
      walk_arc(105, 105, 95, 95, 100, 100, 1'b0, 200);
      walk_arc(-3, 8, 4, -9, 0, 0, 1'b1, 200);
      walk_arc(50, 50, 60, 70, 50, 50, 1'b1, 20);    // zero radius
      drain();
   endtask

   task automatic test_extremes();
      walk_arc(-16384, -16384, 16383, -16384, 16383, 16383, 1'b1, 3);
      walk_arc(16383, 16383, -16384, 16383, -16384, -16384, 1'b0, 3); // restart mid-arc
      walk_arc(16383, -16384, -16384, 16383, 0, 0, 1'b1, 3);
      drain();
   endtask

   task automatic test_random(int pct, int target);
      int goal, r;
      coord_type c_x, c_y;
      gap_pct = pct;
      goal = beats_sent + target;
      while (beats_sent < goal) begin
         r = $urandom_range(99);
         c_x = coord_type'($urandom);
         c_y = coord_type'($urandom);
         if (r < 10) begin
            // full-range noise arc, a few steps only
            walk_arc(coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
                     coord_type'($urandom), c_x, c_y, 1'($urandom),
                     int'($urandom_range(4)));
         end else if (r < 15) begin
            step_beat();
         end else begin
            walk_arc(coord_type'(c_x + coord_type'($urandom_range(24)) - 12),
                     coord_type'(c_y + coord_type'($urandom_range(24)) - 12),
                     coord_type'(c_x + coord_type'($urandom_range(40)) - 20),
                     coord_type'(c_y + coord_type'($urandom_range(40)) - 20),
                     c_x, c_y, 1'($urandom),
                     (r < 30) ? int'($urandom_range(20)) : 400);
         end
      end
      drain();
      gap_pct = 0;
   endtask

   initial begin
      reset         <= 1'b1;
      start         <= 1'b0;
      req_type      <= 1'b0;
      req_start_x   <= '0;
      req_start_y   <= '0;
      req_end_x     <= '0;
      req_end_y     <= '0;
      req_center_x  <= '0;
      req_center_y  <= '0;
      req_clockwise <= 1'b0;
      walking = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_steps();
      test_full_loops();
      test_crossings();
      test_extremes();
      test_random(0, 110);
      test_random(48, 110);
      test_random(27, 110);

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/casg_pkg.sv
hdl/casg_ctrl.sv
hdl/casg_dp.sv
hdl/circular_arc_step_generator.sv
verif/testbench.sv
